// ===== rtl/core/tbpc_pkg.sv =====
// Shared types and constants of the timed blind position controller.
// Holds the motion state codes, request and status codes, register indexes
// and the configuration register set. No dependencies.
package tbpc_pkg;

   // Field and word widths.
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned QUOT_W     = 26;  // elapsed time / 100 fits in 26 bits
   localparam int unsigned RUN_W      = 42;  // quotient times a 16-bit rate
   localparam int unsigned PROD_W     = 64;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   // Division by 100 as a multiplication by a reciprocal (exact for 32-bit values).
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
   localparam int unsigned DIV100_SHIFT = 37;

   // Overshoot beyond the target that turns a stop into a stop for a reverse.
   localparam logic [LEVEL_W-1:0] REVERSE_MARGIN = 16'd2000;

   // Level of an unreferenced blind after reset.
   localparam logic [LEVEL_W-1:0] LEVEL_MID = 16'h8000;

   // Motion state codes.
   localparam logic [2:0] ST_STOP      = 3'd0;
   localparam logic [2:0] ST_PREP_UP   = 3'd1;
   localparam logic [2:0] ST_PREP_DOWN = 3'd2;
   localparam logic [2:0] ST_UP        = 3'd3;
   localparam logic [2:0] ST_DOWN      = 3'd4;

   // Request kinds.
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_UP   = 2'd1;
   localparam logic [1:0] REQ_DOWN = 2'd2;
   localparam logic [1:0] REQ_STOP = 2'd3;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DOWN_START = 2'd1;
   localparam logic [1:0] STATUS_UP_START   = 2'd2;
   localparam logic [1:0] STATUS_END        = 2'd3;

   // Relay modes.
   localparam logic [1:0] MODE_TWO_PHASE = 2'd0;
   localparam logic [1:0] MODE_ACT_UP    = 2'd1;
   localparam logic [1:0] MODE_ACT_DOWN  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_RELAY_MODE    = 3'd0;
   localparam logic [2:0] CSR_CHANGE_RATE   = 3'd1;
   localparam logic [2:0] CSR_STOP_WAIT     = 3'd2;
   localparam logic [2:0] CSR_PREPARE_WAIT  = 3'd3;
   localparam logic [2:0] CSR_UP_END        = 3'd4;
   localparam logic [2:0] CSR_DOWN_END      = 3'd5;
   localparam logic [2:0] CSR_UP_OVERTRAVEL = 3'd6;
   localparam logic [2:0] CSR_DOWN_OVERTRAVEL = 3'd7;

   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic [1:0] relay_mode;
      logic [15:0] change_per_tenth_second;
      logic [15:0] stop_wait_ms;
      logic [15:0] prepare_wait_ms;
      level_type   level_up_end;
      level_type   level_down_end;
      level_type   level_up_overtravel;
      level_type   level_down_overtravel;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      relay_mode:              MODE_TWO_PHASE,
      change_per_tenth_second: 16'd192,
      stop_wait_ms:            16'd1000,
      prepare_wait_ms:         16'd500,
      level_up_end:            16'd4096,
      level_down_end:          16'd61440,
      level_up_overtravel:     16'd0,
      level_down_overtravel:   16'd65535
   };

endpackage

// ===== rtl/core/timed_blind_position_controller_top.sv =====
// Top level of the timed blind position controller.
// Depends on tbpc_pkg for codes, widths and the configuration register set.
//
// The block takes one word per clock cycle while the result side does not stall it,
// and gives one result word for each. The word passes an input stage, an estimate
// stage and the result register, which drives rsp_tvalid. The first stage
// subtracts the last change time from the timestamp and divides the elapsed time
// by 100 through a reciprocal multiplier, for both the stored change time and the
// timestamp of the word ahead, so the estimate stage only selects the right
// quotient. The estimate stage holds the state feedback loop that sets the rate:
// one 26 by 16 multiplier, the position clamp, the end and target compares and
// the update of the motion state, relays and levels. Commands only move the
// target; the relays change on tick words alone. Configuration is to be written
// through csr_we, csr_index and csr_wdata only while no word is in flight; the
// block itself does not enforce this.
module timed_blind_position_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] forced, [32:1] now_ms, [39:33] zero
   input  logic [tbpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  logic [1:0]                          req_tuser,
   // Result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status_code, [2] power_relay, [3] direction_relay,
   // [19:4] target_out, [35:20] position_out, [39:36] zero
   output logic [tbpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration writes
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [15:0]                         csr_wdata
);
   import tbpc_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   // Controller state.
   logic [2:0]        motion_ff, motion_in;
   logic [NOW_W-1:0]  lct_ff, lct_in;
   level_type         known_ff, known_in;
   level_type         target_ff, target_in;
   logic              power_ff, power_in;
   logic              dir_ff, dir_in;

   // Input stage.
   logic              s1_valid_ff;
   logic [1:0]        s1_type_ff;
   logic              s1_forced_ff;
   logic [NOW_W-1:0]  s1_now_ff;

   // Estimate stage.
   logic              s2_valid_ff;
   logic [1:0]        s2_type_ff;
   logic              s2_forced_ff;
   logic [NOW_W-1:0]  s2_now_ff;
   logic [NOW_W-1:0]  s2_el_a_ff, s2_el_b_ff;
   logic [QUOT_W-1:0] s2_q_a_ff, s2_q_b_ff;
   logic              s2_use_b_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_power_ff;
   logic              rsp_dir_ff;
   level_type         rsp_target_ff;
   level_type         rsp_position_ff;

   // Flow control.
   logic out_free, s2_fire, s2_free, s1_move, req_fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_fire    = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || s2_fire;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RELAY_MODE:      cfg_ff.relay_mode <= csr_wdata[1:0];
            CSR_CHANGE_RATE:     cfg_ff.change_per_tenth_second <= csr_wdata;
            CSR_STOP_WAIT:       cfg_ff.stop_wait_ms <= csr_wdata;
            CSR_PREPARE_WAIT:    cfg_ff.prepare_wait_ms <= csr_wdata;
            CSR_UP_END:          cfg_ff.level_up_end <= csr_wdata;
            CSR_DOWN_END:        cfg_ff.level_down_end <= csr_wdata;
            CSR_UP_OVERTRAVEL:   cfg_ff.level_up_overtravel <= csr_wdata;
            CSR_DOWN_OVERTRAVEL: cfg_ff.level_down_overtravel <= csr_wdata;
         endcase
      end
   end

   // Elapsed time and its tenth-second count for both possible change times.
   // Candidate a uses the stored change time, candidate b the timestamp of the
   // word in the estimate stage, which becomes the change time if that word
   // changes state as it leaves.
   logic [NOW_W-1:0]  el_a, el_b;
   logic [PROD_W-1:0] prod_a, prod_b;

   always_comb begin
      el_a   = s1_now_ff - lct_ff;
      el_b   = s1_now_ff - s2_now_ff;
      prod_a = PROD_W'(el_a) * PROD_W'(DIV100_MAGIC);
      prod_b = PROD_W'(el_b) * PROD_W'(DIV100_MAGIC);
   end

   // Position estimate from the selected run time.
   logic [NOW_W-1:0]  el;
   logic [QUOT_W-1:0] quot;
   logic [RUN_W-1:0]  run;
   logic [RUN_W-1:0]  down_sum;
   level_type         up_raw, up_est, down_est, cur;

   always_comb begin
      el       = s2_use_b_ff ? s2_el_b_ff : s2_el_a_ff;
      quot     = s2_use_b_ff ? s2_q_b_ff : s2_q_a_ff;
      run      = RUN_W'(quot) * RUN_W'(cfg_ff.change_per_tenth_second);
      up_raw   = (run >= RUN_W'(known_ff)) ? '0 : known_ff - run[LEVEL_W-1:0];
      up_est   = (up_raw < cfg_ff.level_up_overtravel) ? cfg_ff.level_up_overtravel : up_raw;
      down_sum = RUN_W'(known_ff) + run;
      down_est = (down_sum > RUN_W'(cfg_ff.level_down_overtravel)) ?
                 cfg_ff.level_down_overtravel : down_sum[LEVEL_W-1:0];
      if (motion_ff == ST_UP) begin
         cur = up_est;
      end else if (motion_ff == ST_DOWN) begin
         cur = down_est;
      end else begin
         cur = known_ff;
      end
   end

   // End checks: the clamped stop level and whether the overshoot stays inside
   // the reverse margin.
   level_type clamp_lv;
   logic      near_up, near_down;

   always_comb begin
      if (cur > cfg_ff.level_down_end) begin
         clamp_lv = cfg_ff.level_down_end;
      end else if (cur < cfg_ff.level_up_end) begin
         clamp_lv = cfg_ff.level_up_end;
      end else begin
         clamp_lv = cur;
      end
      near_up   = ({1'b0, cur} + {1'b0, REVERSE_MARGIN}) > {1'b0, target_ff};
      near_down = {1'b0, cur} < ({1'b0, target_ff} + {1'b0, REVERSE_MARGIN});
   end

   // Motion sequencer and command handling.
   logic       lct_chg, halt, go_up, go_down, mode_latched;
   logic [1:0] status_in;
   level_type  pos_in;

   always_comb begin
      motion_in    = motion_ff;
      lct_in       = lct_ff;
      known_in     = known_ff;
      target_in    = target_ff;
      power_in     = power_ff;
      dir_in       = dir_ff;
      status_in    = STATUS_OK;
      lct_chg      = 1'b0;
      halt         = 1'b0;
      go_up        = 1'b0;
      go_down      = 1'b0;
      mode_latched = (cfg_ff.relay_mode == MODE_ACT_UP) ||
                     (cfg_ff.relay_mode == MODE_ACT_DOWN);

      unique case (s2_type_ff)
         REQ_TICK: begin
            priority if (motion_ff == ST_STOP && el >= NOW_W'(cfg_ff.stop_wait_ms)) begin
               if (target_ff > known_ff) begin
                  motion_in = ST_PREP_DOWN;
                  lct_chg   = 1'b1;
                  if (cfg_ff.relay_mode == MODE_ACT_UP) begin
                     dir_in = 1'b0;
                  end else if (cfg_ff.relay_mode == MODE_ACT_DOWN) begin
                     dir_in = 1'b1;
                  end
               end else if (target_ff < known_ff) begin
                  motion_in = ST_PREP_UP;
                  lct_chg   = 1'b1;
                  if (cfg_ff.relay_mode == MODE_ACT_UP) begin
                     dir_in = 1'b1;
                  end else if (cfg_ff.relay_mode == MODE_ACT_DOWN) begin
                     dir_in = 1'b0;
                  end
               end else begin
                  power_in = 1'b0;
                  dir_in   = 1'b0;
               end
            end else if (motion_ff == ST_PREP_DOWN &&
                         el >= NOW_W'(cfg_ff.prepare_wait_ms)) begin
               motion_in = ST_DOWN;
               lct_chg   = 1'b1;
               go_down   = 1'b1;
               status_in = STATUS_DOWN_START;
               if (cfg_ff.relay_mode == MODE_ACT_UP) begin
                  power_in = 1'b1;
                  dir_in   = 1'b0;
               end else if (cfg_ff.relay_mode == MODE_ACT_DOWN) begin
                  power_in = 1'b1;
                  dir_in   = 1'b1;
               end else begin
                  power_in = 1'b0;
                  dir_in   = 1'b1;
               end
            end else if (motion_ff == ST_PREP_UP &&
                         el >= NOW_W'(cfg_ff.prepare_wait_ms)) begin
               motion_in = ST_UP;
               lct_chg   = 1'b1;
               go_up     = 1'b1;
               status_in = STATUS_UP_START;
               power_in  = 1'b1;
               dir_in    = (cfg_ff.relay_mode == MODE_ACT_UP);
            end else if (motion_ff == ST_UP && cur <= target_ff) begin
               halt = 1'b1;
               if (near_up) begin
                  known_in  = clamp_lv;
                  target_in = clamp_lv;
               end else begin
                  known_in = cur;
               end
            end else if (motion_ff == ST_DOWN && cur >= target_ff) begin
               halt = 1'b1;
               if (near_down) begin
                  known_in  = clamp_lv;
                  target_in = clamp_lv;
               end else begin
                  known_in = cur;
               end
            end else begin
               status_in = STATUS_OK;
            end
         end
         REQ_UP: begin
            if (motion_ff == ST_STOP) begin
               target_in = (!s2_forced_ff && known_ff <= cfg_ff.level_up_end) ?
                           cfg_ff.level_down_overtravel : cfg_ff.level_up_overtravel;
            end else begin
               target_in = cur;
            end
         end
         REQ_DOWN: begin
            if (motion_ff == ST_STOP) begin
               target_in = (!s2_forced_ff && known_ff >= cfg_ff.level_down_end) ?
                           cfg_ff.level_up_overtravel : cfg_ff.level_down_overtravel;
            end else begin
               target_in = cur;
            end
         end
         REQ_STOP: begin
            target_in = cur;
         end
      endcase

      // A stop drops power; the direction relay drops only in modes other than act-up and act-down.
      if (halt) begin
         motion_in = ST_STOP;
         lct_chg   = 1'b1;
         status_in = STATUS_END;
         power_in  = 1'b0;
         if (!mode_latched) begin
            dir_in = 1'b0;
         end
      end

      if (lct_chg) begin
         lct_in = s2_now_ff;
      end

      // Position after the word: zero run time wherever the change time moved.
      if (halt) begin
         pos_in = known_in;
      end else if (go_down) begin
         pos_in = (known_ff > cfg_ff.level_down_overtravel) ?
                  cfg_ff.level_down_overtravel : known_ff;
      end else if (go_up) begin
         pos_in = (known_ff < cfg_ff.level_up_overtravel) ?
                  cfg_ff.level_up_overtravel : known_ff;
      end else begin
         pos_in = cur;
      end
   end

   // Pipeline valid bits and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         motion_ff    <= ST_STOP;
         lct_ff       <= '0;
         known_ff     <= LEVEL_MID;
         target_ff    <= LEVEL_MID;
         power_ff     <= 1'b0;
         dir_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (s2_fire) begin
            motion_ff <= motion_in;
            lct_ff    <= lct_in;
            known_ff  <= known_in;
            target_ff <= target_in;
            power_ff  <= power_in;
            dir_ff    <= dir_in;
         end
      end
   end

   // Payload registers of the three stages.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff   <= req_tuser;
         s1_forced_ff <= req_tdata[0];
         s1_now_ff    <= req_tdata[NOW_W:1];
      end
      if (s1_move) begin
         s2_type_ff   <= s1_type_ff;
         s2_forced_ff <= s1_forced_ff;
         s2_now_ff    <= s1_now_ff;
         s2_el_a_ff   <= el_a;
         s2_el_b_ff   <= el_b;
         s2_q_a_ff    <= prod_a[DIV100_SHIFT +: QUOT_W];
         s2_q_b_ff    <= prod_b[DIV100_SHIFT +: QUOT_W];
         s2_use_b_ff  <= s2_fire && lct_chg;
      end
      if (s2_fire) begin
         rsp_status_ff   <= status_in;
         rsp_power_ff    <= power_in;
         rsp_dir_ff      <= dir_in;
         rsp_target_ff   <= target_in;
         rsp_position_ff <= pos_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_position_ff, rsp_target_ff,
                        rsp_dir_ff, rsp_power_ff, rsp_status_ff};

   // The motor is never powered while the direction is still settling.
   a_prep_unpowered: assert property (@(posedge clock) disable iff (reset)
      (motion_ff == ST_PREP_UP || motion_ff == ST_PREP_DOWN) |-> !power_ff)
      else $error("motor powered during direction settle");

   // Upward motion is only entered from its settle state.
   a_up_entry: assert property (@(posedge clock) disable iff (reset)
      (motion_ff == ST_UP && $past(motion_ff) != ST_UP) |-> $past(motion_ff) == ST_PREP_UP)
      else $error("up motion entered without settle");

   // Downward motion is only entered from its settle state.
   a_down_entry: assert property (@(posedge clock) disable iff (reset)
      (motion_ff == ST_DOWN && $past(motion_ff) != ST_DOWN) |->
      $past(motion_ff) == ST_PREP_DOWN)
      else $error("down motion entered without settle");

   // An end status goes out only together with an actual stop.
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && status_in == STATUS_END) |=> (motion_ff == ST_STOP && !power_ff))
      else $error("end status without motor stop");

   // A word held in the estimate stage keeps its timestamp while it waits.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_now_ff)))
      else $error("estimate stage word lost while stalled");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the timed blind position controller.
// Drives timestamped tick and command words, predicts every result word with its own
// model of the motion sequencer, and compares each field. Depends on tbpc_pkg.
module testbench;
   import tbpc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 6;
   localparam int OVERSHOOT_MARGIN = int'(REVERSE_MARGIN);
   localparam longint unsigned LEVEL_CEILING = 65535;
   // Relay mode code that the block does not name; it must act as two phases.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] status;
      logic       power;
      logic       direction;
      level_type  target;
      level_type  position;
   } blind_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = REQ_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_index = CSR_RELAY_MODE;
   logic [15:0]           csr_wdata = '0;

   // Predicted controller state and register copy.
   cfg_type     cfg = CFG_RESET;
   logic [2:0]  motion = ST_STOP;
   logic [31:0] changed_at = '0;
   level_type   known_lvl = LEVEL_MID;
   level_type   target_lvl = LEVEL_MID;
   logic        power_on = 1'b0;
   logic        direction_on = 1'b0;

   blind_result_type awaited_results[$];
   int            mismatch_count = 0;
   int            words_sent = 0;
   int            idle_cycles = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   logic          hold_rsp = 1'b0;
   logic [31:0]   wall_ms = '0;

   always #5 clock = ~clock;

   timed_blind_position_controller_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Position estimate from run time since the last change, saturated and clamped.
   function automatic level_type estimated_level(input logic [31:0] stamp);
      logic [31:0]     elapsed;
      longint unsigned run;
      longint unsigned lvl;
      elapsed = stamp - changed_at;
      run = 64'(elapsed / 32'd100);
      run = run * 64'(cfg.change_per_tenth_second);
      if (motion == ST_UP) begin
         if (run >= 64'(known_lvl)) lvl = 0;
         else lvl = 64'(known_lvl) - run;
         if (lvl < 64'(cfg.level_up_overtravel)) lvl = 64'(cfg.level_up_overtravel);
      end else if (motion == ST_DOWN) begin
         lvl = 64'(known_lvl) + run;
         if (lvl > LEVEL_CEILING) lvl = LEVEL_CEILING;
         if (lvl > 64'(cfg.level_down_overtravel)) lvl = 64'(cfg.level_down_overtravel);
      end else begin
         lvl = 64'(known_lvl);
      end
      return level_type'(lvl);
   endfunction

   // A normal stop pins the level between the end levels, down end tested first.
   function automatic level_type end_clamped(input level_type lvl);
      if (lvl > cfg.level_down_end) return cfg.level_down_end;
      if (lvl < cfg.level_up_end) return cfg.level_up_end;
      return lvl;
   endfunction

   function automatic void stop_motor(input logic [31:0] stamp);
      motion = ST_STOP;
      changed_at = stamp;
      power_on = 1'b0;
      if (cfg.relay_mode != MODE_ACT_UP && cfg.relay_mode != MODE_ACT_DOWN) begin
         direction_on = 1'b0;
      end
   endfunction

   // Relay sequencing on a tick word; returns the status code.
   function automatic logic [1:0] tick_controller(input logic [31:0] stamp);
      logic [31:0] elapsed;
      level_type   cur;
      elapsed = stamp - changed_at;
      if (motion == ST_STOP && elapsed >= 32'(cfg.stop_wait_ms)) begin
         if (target_lvl > known_lvl) begin
            motion = ST_PREP_DOWN;
            changed_at = stamp;
            if (cfg.relay_mode == MODE_ACT_UP) direction_on = 1'b0;
            else if (cfg.relay_mode == MODE_ACT_DOWN) direction_on = 1'b1;
         end else if (target_lvl < known_lvl) begin
            motion = ST_PREP_UP;
            changed_at = stamp;
            if (cfg.relay_mode == MODE_ACT_UP) direction_on = 1'b1;
            else if (cfg.relay_mode == MODE_ACT_DOWN) direction_on = 1'b0;
         end else begin
            power_on = 1'b0;
            direction_on = 1'b0;
         end
         return STATUS_OK;
      end
      if (motion == ST_PREP_DOWN && elapsed >= 32'(cfg.prepare_wait_ms)) begin
         motion = ST_DOWN;
         changed_at = stamp;
         if (cfg.relay_mode == MODE_ACT_UP) begin
            power_on = 1'b1;
            direction_on = 1'b0;
         end else if (cfg.relay_mode == MODE_ACT_DOWN) begin
            power_on = 1'b1;
            direction_on = 1'b1;
         end else begin
            power_on = 1'b0;
            direction_on = 1'b1;
         end
         return STATUS_DOWN_START;
      end
      if (motion == ST_PREP_UP && elapsed >= 32'(cfg.prepare_wait_ms)) begin
         motion = ST_UP;
         changed_at = stamp;
         power_on = 1'b1;
         direction_on = (cfg.relay_mode == MODE_ACT_UP);
         return STATUS_UP_START;
      end
      cur = estimated_level(stamp);
      // Target reached: a small overshoot is a normal stop, a large one keeps the
      // true level so that the next ticks reverse.
      if (motion == ST_UP && cur <= target_lvl) begin
         if (int'(cur) > int'(target_lvl) - OVERSHOOT_MARGIN) begin
            known_lvl = end_clamped(cur);
            target_lvl = known_lvl;
         end else begin
            known_lvl = cur;
         end
         stop_motor(stamp);
         return STATUS_END;
      end
      if (motion == ST_DOWN && cur >= target_lvl) begin
         if (int'(cur) < int'(target_lvl) + OVERSHOOT_MARGIN) begin
            known_lvl = end_clamped(cur);
            target_lvl = known_lvl;
         end else begin
            known_lvl = cur;
         end
         stop_motor(stamp);
         return STATUS_END;
      end
      return STATUS_OK;
   endfunction

   // Expected result word for one accepted request word.
   function automatic blind_result_type predict_word(input logic [1:0] kind,
                                                     input logic forced,
                                                     input logic [31:0] stamp);
      blind_result_type res;
      res.status = STATUS_OK;
      case (kind)
         REQ_TICK: begin
            res.status = tick_controller(stamp);
         end
         REQ_UP: begin
            if (motion == ST_STOP) begin
               target_lvl = (!forced && known_lvl <= cfg.level_up_end) ?
                            cfg.level_down_overtravel : cfg.level_up_overtravel;
            end else begin
               target_lvl = estimated_level(stamp);
            end
         end
         REQ_DOWN: begin
            if (motion == ST_STOP) begin
               target_lvl = (!forced && known_lvl >= cfg.level_down_end) ?
                            cfg.level_up_overtravel : cfg.level_down_overtravel;
            end else begin
               target_lvl = estimated_level(stamp);
            end
         end
         default: begin
            target_lvl = estimated_level(stamp);
         end
      endcase
      res.power = power_on;
      res.direction = direction_on;
      res.target = target_lvl;
      res.position = estimated_level(stamp);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
   endtask

   // Result side ready, with random stalls and an optional long hold-off.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      blind_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_tdata), 64'd0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status_code", 64'(rsp_tdata[1:0]), 64'(want.status));
            if (rsp_tdata[2] !== want.power)
               report_mismatch("power_relay", 64'(rsp_tdata[2]), 64'(want.power));
            if (rsp_tdata[3] !== want.direction)
               report_mismatch("direction_relay", 64'(rsp_tdata[3]), 64'(want.direction));
            if (rsp_tdata[19:4] !== want.target)
               report_mismatch("target_out", 64'(rsp_tdata[19:4]), 64'(want.target));
            if (rsp_tdata[35:20] !== want.position)
               report_mismatch("position_out", 64'(rsp_tdata[35:20]), 64'(want.position));
            if (rsp_tdata[39:36] !== 4'b0)
               report_mismatch("padding", 64'(rsp_tdata[39:36]), 64'd0);
         end
      end
   end

   // Watchdog on cycles in which no word and no register write is accepted.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request word, with random gaps, and predict it once accepted.
   task automatic send_word(input logic [1:0] kind, input logic forced,
                            input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_DATA_W - NOW_W - 1){1'b0}}, stamp, forced};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_results.push_back(predict_word(kind, forced, stamp));
      words_sent++;
      wall_ms = stamp;
   endtask

   task automatic send_tick(input int unsigned advance);
      send_word(REQ_TICK, 1'($urandom_range(1)), wall_ms + advance);
   endtask

   // Stop offering and wait until every expected word has come out.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_RELAY_MODE:      cfg.relay_mode = value[1:0];
         CSR_CHANGE_RATE:     cfg.change_per_tenth_second = value;
         CSR_STOP_WAIT:       cfg.stop_wait_ms = value;
         CSR_PREPARE_WAIT:    cfg.prepare_wait_ms = value;
         CSR_UP_END:          cfg.level_up_end = value;
         CSR_DOWN_END:        cfg.level_down_end = value;
         CSR_UP_OVERTRAVEL:   cfg.level_up_overtravel = value;
         default:             cfg.level_down_overtravel = value;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [15:0] rate,
                            input logic [15:0] stop_wait, input logic [15:0] prep_wait,
                            input logic [15:0] up_end, input logic [15:0] down_end,
                            input logic [15:0] up_over, input logic [15:0] down_over);
      settle();
      write_csr(CSR_RELAY_MODE, {14'b0, mode});
      write_csr(CSR_CHANGE_RATE, rate);
      write_csr(CSR_STOP_WAIT, stop_wait);
      write_csr(CSR_PREPARE_WAIT, prep_wait);
      write_csr(CSR_UP_END, up_end);
      write_csr(CSR_DOWN_END, down_end);
      write_csr(CSR_UP_OVERTRAVEL, up_over);
      write_csr(CSR_DOWN_OVERTRAVEL, down_over);
   endtask

   // Mostly a command followed by a run of ticks so the motor gets to move and stop;
   // the rest is noise with random kinds and timestamps, some running backwards.
   task automatic random_motion(input int count, input int unsigned step_max);
      int         last_word;
      int         ticks;
      logic [1:0] kind;
      last_word = words_sent + count;
      while (words_sent < last_word) begin
         if ($urandom_range(99) < 85) begin
            case ($urandom_range(2))
               0:       kind = REQ_UP;
               1:       kind = REQ_DOWN;
               default: kind = REQ_STOP;
            endcase
            send_word(kind, 1'($urandom_range(1)), wall_ms + $urandom_range(step_max));
            ticks = $urandom_range(3, 24);
            repeat (ticks) begin
               if ($urandom_range(19) == 0) send_tick($urandom_range(step_max * 20));
               else send_tick($urandom_range(step_max));
            end
         end else begin
            kind = 2'($urandom_range(3));
            if ($urandom_range(1) == 0) begin
               send_word(kind, 1'($urandom_range(1)), $urandom());
            end else begin
               send_word(kind, 1'($urandom_range(1)), wall_ms - $urandom_range(step_max));
            end
         end
      end
   endtask

   // Directed run with reset registers: a full down move, a stop command, an up move
   // that saturates at the floor, time wrap, end reversal at both ends and a down
   // move that saturates at the ceiling.
   task automatic test_directed_motion();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(REQ_TICK, 1'b0, 32'd0);
      send_word(REQ_DOWN, 1'b1, 32'd10);
      send_word(REQ_TICK, 1'b0, 32'd1000);
      send_word(REQ_TICK, 1'b1, 32'd1499);
      send_word(REQ_TICK, 1'b0, 32'd1500);
      send_word(REQ_TICK, 1'b0, 32'd2500);
      send_word(REQ_STOP, 1'b0, 32'd3000);
      send_word(REQ_TICK, 1'b0, 32'd3000);
      send_word(REQ_UP, 1'b0, 32'd3100);
      send_word(REQ_TICK, 1'b0, 32'd4100);
      send_word(REQ_TICK, 1'b0, 32'd4600);
      send_word(REQ_TICK, 1'b1, 32'hFFFF_FFFF);
      send_word(REQ_TICK, 1'b0, 32'd998);
      send_word(REQ_TICK, 1'b0, 32'd999);
      send_word(REQ_UP, 1'b0, 32'd1200);
      send_word(REQ_DOWN, 1'b0, 32'd1300);
      send_word(REQ_UP, 1'b1, 32'd1400);
      send_word(REQ_DOWN, 1'b1, 32'd1500);
      send_word(REQ_TICK, 1'b0, 32'd2000);
      send_word(REQ_TICK, 1'b0, 32'd2500);
      send_word(REQ_TICK, 1'b0, 32'h8000_0000);
      send_word(REQ_UP, 1'b0, 32'h8000_0010);
      send_word(REQ_DOWN, 1'b0, 32'h8000_0020);
      send_word(REQ_STOP, 1'b1, 32'h8000_0030);
   endtask

   // Every relay mode, each with its own idling profile and rate extremes.
   task automatic test_relay_modes();
      configure(MODE_TWO_PHASE, 16'd192, 16'd1000, 16'd500, 16'd4096, 16'd61440, 16'd0,
                16'd65535);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_motion(400, 600);
      configure(MODE_ACT_UP, 16'd2000, 16'd200, 16'd100, 16'd4096, 16'd61440, 16'd0,
                16'd65535);
      send_idle_pct = 55;
      rsp_stall_pct = 0;
      random_motion(400, 300);
      configure(MODE_ACT_DOWN, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
      send_idle_pct = 0;
      rsp_stall_pct = 55;
      random_motion(400, 300);
      configure(MODE_UNUSED, 16'd1, 16'd65535, 16'd65535, 16'd4096, 16'd61440, 16'd0,
                16'd65535);
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      random_motion(300, 40000);
   endtask

   // Crossed end levels and crossed overtravel floor and ceiling.
   task automatic test_end_registers();
      configure(MODE_TWO_PHASE, 16'd500, 16'd50, 16'd50, 16'd60000, 16'd5000, 16'd1000,
                16'd64000);
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      random_motion(200, 400);
      configure(MODE_ACT_UP, 16'd3000, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_motion(160, 3000);
   endtask

   // Result side held off for a long stretch while words keep coming, so the
   // pipeline fills and the request side stalls.
   task automatic test_backpressure();
      configure(MODE_ACT_DOWN, 16'd800, 16'd100, 16'd100, 16'd4096, 16'd61440, 16'd0,
                16'd65535);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         random_motion(60, 200);
      join
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_motion();
      test_relay_modes();
      test_end_registers();
      test_backpressure();
      settle();
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tbpc_pkg.sv
rtl/core/timed_blind_position_controller_top.sv
tb/testbench.sv
